### hw/rtl/scfps_pkg.sv
// ----------------------------------------------------------------------------
// scfps_pkg
// Types and constants shared by the scaled copy / five-point smooth block.
// ----------------------------------------------------------------------------
package scfps_pkg;

	// Image store geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 8;
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int IMG_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

	// Request kinds
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCALE_RATIO   = 2'd0;
	localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] RATIO_RESET  = 8'd16;
	localparam logic [8:0] WIDTH_RESET  = 9'd256;
	localparam logic [8:0] HEIGHT_RESET = 9'd256;
	localparam logic [7:0] RATIO_UNITY  = 8'd16;

	// Read sequence of one smoothed pixel
	localparam logic [2:0] RD_CENTRE = 3'd0;
	localparam logic [2:0] RD_LEFT   = 3'd1;
	localparam logic [2:0] RD_RIGHT  = 3'd2;
	localparam logic [2:0] RD_UP     = 3'd3;
	localparam logic [2:0] RD_DOWN   = 3'd4;

	// Coordinate divider: 8 quotient bits, 4 per cycle
	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = 2;

	// Divide by six: floor(s / 6) == (s * 2731) >> 14 for s < 8192
	localparam logic [11:0] DIV6_MUL   = 12'd2731;
	localparam int          DIV6_SHIFT = 14;

	// Results allowed in flight between the read sequencer and the output
	localparam logic [1:0] RSP_CREDITS = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  src_col;
		logic [7:0]  src_row;
		logic [11:0] dst_col;
		logic [11:0] dst_row;
		logic [7:0]  in_blue;
		logic [7:0]  in_green;
		logic [7:0]  in_red;
		logic [7:0]  in_alpha;
	} scfps_req_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
		logic       out_of_range;
	} scfps_rsp_t;

endpackage

### hw/rtl/scaled_copy_five_point_smooth.sv
// ----------------------------------------------------------------------------
// scaled_copy_five_point_smooth
// Holds a 256x256 BGRA source image in one single-port memory (64K x 32) and
// answers queries for pixels of a scaled copy, smoothing b, g and r over the
// centre pixel (weight two) and its four neighbours, with the centre standing
// in for neighbours past the border. Stores run one per cycle when no query
// ahead of them stalls the hand-off. A smoothed query makes five reads
// (centre, left, right, up, down) through the single image port; a query at
// ratio 16 or outside the scaled size makes one. Smoothed queries are
// therefore limited by the image memory port. The source coordinate is found
// by a divider that works on the next word while the memory serves the
// current one; a query holds the divider stage until its division is done
// and it is handed off, which limits the rate of unity-ratio and
// out-of-range queries. A result passes through the divider stage, the read
// sequencer, the registered memory read, the accumulate stage and the finish
// stage into the output queue, where up to two results wait. The image
// memory has no reset: every pixel a query touches must be stored first.
// Configuration writes take effect at once; make them only while no word is
// in flight.
// ----------------------------------------------------------------------------
module scaled_copy_five_point_smooth
	import scfps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       req_valid,
	output logic       req_ready,
	input  scfps_req_t req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output scfps_rsp_t rsp_data
);

	// Configuration
	logic [7:0]  ratio_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	logic [7:0]  ratio_eff;
	logic [8:0]  w_eff;
	logic [8:0]  h_eff;
	logic [12:0] neww_q;
	logic [12:0] newh_q;
	logic        ratio_unity;

	// Divider stage
	logic        v_s1;
	scfps_req_t  item_s1;
	logic [7:0]  remx_s1;
	logic [7:0]  remy_s1;
	logic [7:0]  lowx_s1;
	logic [7:0]  lowy_s1;
	logic [7:0]  qx_s1;
	logic [7:0]  qy_s1;
	logic [1:0]  cnt_s1;
	logic        done_s1;
	logic [11:0] stepx;
	logic [11:0] stepy;

	// Hand-off into the read sequencer
	logic        handoff;
	logic [7:0]  hx1;
	logic [7:0]  hy1;
	logic [7:0]  hx0;
	logic [7:0]  hx2;
	logic [7:0]  hy0;
	logic [7:0]  hy2;
	logic        hoor;
	logic [1:0]  credit_q;

	// Read sequencer stage
	logic        v_s2;
	logic        wr_s2;
	logic        oor_s2;
	logic        r16_s2;
	logic [7:0]  x0_s2;
	logic [7:0]  x1_s2;
	logic [7:0]  x2_s2;
	logic [7:0]  y0_s2;
	logic [7:0]  y1_s2;
	logic [7:0]  y2_s2;
	logic [31:0] wdata_s2;
	logic [2:0]  cnt_s2;
	logic        last_s2;
	logic        done_s2;
	logic        free_s2;
	logic        mem_we;
	logic [ADDR_W-1:0] mem_addr;

	// Image memory
	logic [31:0] img_mem [IMG_DEPTH];
	logic [31:0] rdata_q;

	// Accumulate stage
	logic        v_s3;
	logic [2:0]  sel_s3;
	logic        last_s3;
	logic        oor_s3;
	logic        r16_s3;
	logic [10:0] acc_q [3];
	logic [7:0]  alpha_q;

	// Finish stage
	logic        v_s4;
	logic        oor_s4;
	logic        r16_s4;
	logic [10:0] sum_s4 [3];
	logic [7:0]  alpha_s4;
	logic [22:0] prod [3];
	logic [7:0]  quot [3];
	scfps_rsp_t  res;

	// Output queue
	scfps_rsp_t  fifo_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        rsp_take;

	// Four restoring divide steps; a quotient below 256 keeps the remainder
	// in eight bits
	function automatic logic [11:0] div_step4(input logic [7:0] rem_in,
			input logic [3:0] bits, input logic [7:0] dvs);
		logic [7:0] rem;
		logic [8:0] r9;
		logic [3:0] q;
		rem = rem_in;
		q   = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r9 = {rem, bits[DIV_STEPS-1-i]};
			if (r9 >= {1'b0, dvs}) begin
				r9 = r9 - {1'b0, dvs};
				q[DIV_STEPS-1-i] = 1'b1;
			end
			rem = r9[7:0];
		end
		return {rem, q};
	endfunction

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCALE_RATIO:   ratio_q  <= cfg_data[7:0];
				CFG_SOURCE_WIDTH:  width_q  <= cfg_data;
				CFG_SOURCE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp ratio and dimensions into their working range
	always_comb begin
		ratio_eff = (ratio_q == 8'd0) ? 8'd1 : ratio_q;
		if (width_q == 9'd0) begin
			w_eff = 9'd1;
		end else if (width_q > 9'(MAX_WIDTH)) begin
			w_eff = 9'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == 9'd0) begin
			h_eff = 9'd1;
		end else if (height_q > 9'(MAX_HEIGHT)) begin
			h_eff = 9'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		ratio_unity = (ratio_eff == RATIO_UNITY);
	end

	// Scaled output size; settles well before any query uses it
	always_ff @(posedge clk) begin
		neww_q <= 13'(({8'd0, w_eff} * {9'd0, ratio_eff}) >> 4);
		newh_q <= 13'(({8'd0, h_eff} * {9'd0, ratio_eff}) >> 4);
	end

	// Divider stage: accept a word, divide both coordinates of a query by the ratio
	assign stepx   = div_step4(remx_s1, lowx_s1[7:4], ratio_eff);
	assign stepy   = div_step4(remy_s1, lowy_s1[7:4], ratio_eff);
	assign done_s1 = (item_s1.req_type == REQ_STORE) || (cnt_s1 == 2'(DIV_CYCLES));

	assign handoff   = v_s1 && done_s1 && free_s2 &&
		((item_s1.req_type == REQ_STORE) || (credit_q < RSP_CREDITS));
	assign req_ready = !v_s1 || handoff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cnt_s1 <= '0;
		end else if (req_valid && req_ready) begin
			v_s1   <= 1'b1;
			cnt_s1 <= '0;
		end else if (handoff) begin
			v_s1   <= 1'b0;
		end else if (v_s1 && !done_s1) begin
			cnt_s1 <= cnt_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_data;
			remx_s1 <= req_data.dst_col[11:4];
			remy_s1 <= req_data.dst_row[11:4];
			lowx_s1 <= {req_data.dst_col[3:0], 4'd0};
			lowy_s1 <= {req_data.dst_row[3:0], 4'd0};
			qx_s1   <= '0;
			qy_s1   <= '0;
		end else if (v_s1 && !done_s1) begin
			remx_s1 <= stepx[11:4];
			remy_s1 <= stepy[11:4];
			qx_s1   <= {qx_s1[3:0], stepx[3:0]};
			qy_s1   <= {qy_s1[3:0], stepy[3:0]};
			lowx_s1 <= {lowx_s1[3:0], 4'd0};
			lowy_s1 <= {lowy_s1[3:0], 4'd0};
		end
	end

	// Centre and neighbour coordinates; an in-range query always has x1 < w
	always_comb begin
		if (item_s1.req_type == REQ_STORE) begin
			hx1 = item_s1.src_col;
			hy1 = item_s1.src_row;
		end else begin
			hx1 = qx_s1;
			hy1 = qy_s1;
		end
		hx0  = (hx1 != 8'd0) ? hx1 - 8'd1 : hx1;
		hy0  = (hy1 != 8'd0) ? hy1 - 8'd1 : hy1;
		hx2  = (({1'b0, hx1} + 9'd1) < w_eff) ? hx1 + 8'd1 : hx1;
		hy2  = (({1'b0, hy1} + 9'd1) < h_eff) ? hy1 + 8'd1 : hy1;
		hoor = ({1'b0, item_s1.dst_col} >= neww_q) || ({1'b0, item_s1.dst_row} >= newh_q);
	end

	// Count results in flight so the output queue never overflows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q
				+ 2'(handoff && (item_s1.req_type == REQ_QUERY))
				- 2'(rsp_take);
		end
	end

	// Read sequencer: one memory access per cycle
	always_comb begin
		if (wr_s2 || oor_s2 || r16_s2) begin
			last_s2 = (cnt_s2 == RD_CENTRE);
		end else begin
			last_s2 = (cnt_s2 == RD_DOWN);
		end
	end
	assign done_s2 = v_s2 && last_s2;
	assign free_s2 = !v_s2 || done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			cnt_s2 <= RD_CENTRE;
		end else if (handoff) begin
			v_s2   <= 1'b1;
			cnt_s2 <= RD_CENTRE;
		end else if (done_s2) begin
			v_s2   <= 1'b0;
		end else if (v_s2) begin
			cnt_s2 <= cnt_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff) begin
			wr_s2    <= (item_s1.req_type == REQ_STORE);
			oor_s2   <= hoor;
			r16_s2   <= ratio_unity;
			x0_s2    <= hx0;
			x1_s2    <= hx1;
			x2_s2    <= hx2;
			y0_s2    <= hy0;
			y1_s2    <= hy1;
			y2_s2    <= hy2;
			wdata_s2 <= {item_s1.in_alpha, item_s1.in_red, item_s1.in_green,
				item_s1.in_blue};
		end
	end

	// Select the address of this cycle's access
	assign mem_we = v_s2 && wr_s2;
	always_comb begin
		case (cnt_s2)
			RD_CENTRE: mem_addr = {y1_s2, x1_s2};
			RD_LEFT:   mem_addr = {y1_s2, x0_s2};
			RD_RIGHT:  mem_addr = {y1_s2, x2_s2};
			RD_UP:     mem_addr = {y0_s2, x1_s2};
			RD_DOWN:   mem_addr = {y2_s2, x1_s2};
			default:   mem_addr = {y1_s2, x1_s2};
		endcase
	end

	// Image memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			img_mem[mem_addr] <= wdata_s2;
		end
		rdata_q <= img_mem[mem_addr];
	end

	// Track read data, which arrives in the cycle after the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && !wr_s2;
			v_s4 <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		sel_s3  <= cnt_s2;
		last_s3 <= last_s2;
		oor_s3  <= oor_s2;
		r16_s3  <= r16_s2;
	end

	// Accumulate the weighted sum; hand the finished sum to the last stage
	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int k = 0; k < 3; k++) begin
				if (sel_s3 == RD_CENTRE) begin
					acc_q[k] <= {2'd0, rdata_q[8*k +: 8], 1'b0};
				end else begin
					acc_q[k] <= acc_q[k] + {3'd0, rdata_q[8*k +: 8]};
				end
				if (r16_s3) begin
					sum_s4[k] <= {3'd0, rdata_q[8*k +: 8]};
				end else begin
					sum_s4[k] <= acc_q[k] + {3'd0, rdata_q[8*k +: 8]};
				end
			end
			if (sel_s3 == RD_CENTRE) begin
				alpha_q  <= rdata_q[31:24];
				alpha_s4 <= rdata_q[31:24];
			end else begin
				alpha_s4 <= alpha_q;
			end
			oor_s4 <= oor_s3;
			r16_s4 <= r16_s3;
		end
	end

	// Divide smoothed sums by six and build the result word
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = {12'd0, sum_s4[k]} * {11'd0, DIV6_MUL};
			quot[k] = 8'(prod[k] >> DIV6_SHIFT);
		end
		res = '0;
		if (oor_s4) begin
			res.out_of_range = 1'b1;
		end else if (r16_s4) begin
			res.out_blue  = sum_s4[0][7:0];
			res.out_green = sum_s4[1][7:0];
			res.out_red   = sum_s4[2][7:0];
			res.out_alpha = alpha_s4;
		end else begin
			res.out_blue  = quot[0];
			res.out_green = quot[1];
			res.out_red   = quot[2];
			res.out_alpha = alpha_s4;
		end
	end

	// Output queue, two words
	assign rsp_valid = (count_q != 2'd0);
	assign rsp_data  = fifo_q[rptr_q];
	assign rsp_take  = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (v_s4) begin
				wptr_q <= !wptr_q;
			end
			if (rsp_take) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(v_s4) - 2'(rsp_take);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_q[wptr_q] <= res;
		end
	end

endmodule
